### hdl/espid_pkg.sv
// ----------------------------------------------------------------------------
// espid_pkg
// shared widths, register indexes, reset values and saturation helpers for
// the encoder speed incremental pid controller
// ----------------------------------------------------------------------------
package espid_pkg;

   // default counter wrap width
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // field widths
   localparam int ENC_WIDTH   = 16;
   localparam int DUTY_WIDTH  = 16;
   localparam int SPEED_WIDTH = 32;
   localparam int GAIN_WIDTH  = 32;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // fraction bits dropped from the gain * error sum
   localparam int GAIN_FRAC_SHIFT = 20;

   // register reset values
   localparam logic [15:0] SPEED_SCALE_RESET = 16'd233;
   localparam logic [15:0] DUTY_MAX_RESET    = 16'd10000;
   localparam logic [15:0] SMALL_STEP_RESET  = 16'd50;

   // register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_SPEED_TARGET = 3'd0,
      REG_SPEED_SCALE  = 3'd1,
      REG_GAIN_NOW     = 3'd2,
      REG_GAIN_PREV    = 3'd3,
      REG_GAIN_PREV2   = 3'd4,
      REG_DUTY_MAX     = 3'd5,
      REG_SMALL_STEP   = 3'd6
   } csr_index_type;

   // saturate a 64-bit signed value to 32 bits signed
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // 64-bit signed add with saturation at the signed limits
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [63:0] r;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

endpackage

### hdl/encoder_speed_incremental_pid.sv
// ----------------------------------------------------------------------------
// encoder_speed_incremental_pid
// quadrature encoder speed loop with a velocity-form pid, one result per tick
// ----------------------------------------------------------------------------
// sequence: a run tick steps through muls, speed, err, mul0, mul1, mul2, acc
//   and update, a stop tick through muls and speed; one shared 33x33
//   multiplier is stepped by the fsm; ticks are taken one at a time, and
//   the next is taken while a finished result waits in the output register
// reset: synchronous, clears registers to defaults, history, duty and counter
// ----------------------------------------------------------------------------
module encoder_speed_incremental_pid #(
   parameter int COUNT_WIDTH = espid_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input ticks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] encoder_count
   input  logic        req_tuser,   // [0] run
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] duty, [47:16] speed_measured
   output logic        rsp_tuser,   // [0] enable
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // sequencer states
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MULS   = 9'b000000010,
      ST_SPEED  = 9'b000000100,
      ST_ERR    = 9'b000001000,
      ST_MUL0   = 9'b000010000,
      ST_MUL1   = 9'b000100000,
      ST_MUL2   = 9'b001000000,
      ST_ACC    = 9'b010000000,
      ST_UPDATE = 9'b100000000
   } state_type;

   localparam int OPW = 33;
   localparam int INCW = 64 - espid_pkg::GAIN_FRAC_SHIFT;

   // configuration registers
   logic signed [31:0] speed_target_ff;
   logic [15:0]        speed_scale_ff;
   logic signed [31:0] gain_now_ff, gain_prev_ff, gain_prev2_ff;
   logic [15:0]        duty_max_ff, small_step_ff;

   // control state
   state_type          state_ff, state_in;
   logic               done_ff, done_in;
   logic [COUNT_WIDTH-1:0] prev_count_ff, prev_count_in;
   logic               running_ff, running_in;
   logic [15:0]        last_duty_ff, last_duty_in;
   logic signed [31:0] err_prev_ff, err_prev_in;
   logic signed [31:0] err_prev2_ff, err_prev2_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [COUNT_WIDTH-1:0] diff_ff, diff_in;
   logic               run_ff, run_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [31:0] err_ff, err_in;
   logic [47:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   // shared multiplier
   logic signed [OPW-1:0]   mul_a, mul_b;
   logic signed [2*OPW-1:0] mul_p;

   logic [COUNT_WIDTH-1:0] cnt;
   logic signed [INCW-1:0] inc;
   logic signed [INCW+1:0] next_duty;
   logic [INCW+1:0]        inc_mag;
   logic                   req_beat, out_free;

   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !done_ff;
   assign csr_ready  = 1'b1;
   assign cnt        = COUNT_WIDTH'(req_tdata);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MULS: begin
            mul_a = OPW'(signed'(diff_ff));
            mul_b = signed'(OPW'(speed_scale_ff));
         end
         ST_MUL0: begin
            mul_a = OPW'(gain_now_ff);
            mul_b = OPW'(err_ff);
         end
         ST_MUL1: begin
            mul_a = OPW'(gain_prev_ff);
            mul_b = OPW'(err_prev_ff);
         end
         ST_MUL2: begin
            mul_a = OPW'(gain_prev2_ff);
            mul_b = OPW'(err_prev2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // duty update terms, floor shift of the accumulated sum
   assign inc       = acc_ff[63:espid_pkg::GAIN_FRAC_SHIFT];
   assign next_duty = signed'((INCW+2)'(last_duty_ff)) + (INCW+2)'(inc);
   assign inc_mag   = inc[INCW-1] ? (INCW+2)'(-((INCW+2)'(inc))) : (INCW+2)'(inc);

   // sequencer and next values
   always_comb begin
      state_in      = state_ff;
      done_in       = done_ff;
      prev_count_in = prev_count_ff;
      running_in    = running_ff;
      last_duty_in  = last_duty_ff;
      err_prev_in   = err_prev_ff;
      err_prev2_in  = err_prev2_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      diff_in       = diff_ff;
      run_in        = run_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      speed_in      = speed_ff;
      err_in        = err_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      case (state_ff)
         ST_IDLE: begin
            // hand a finished tick to the output register
            if (done_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {speed_ff, last_duty_ff};
               rsp_user_in  = running_ff;
               done_in      = 1'b0;
            end else if (req_beat) begin
               diff_in       = cnt - prev_count_ff;
               prev_count_in = cnt;
               run_in        = req_tuser;
               state_in      = ST_MULS;
            end
         end
         ST_MULS: begin
            prod_in  = mul_p[63:0];
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            speed_in = espid_pkg::sat32(prod_ff);
            if (run_ff) begin
               state_in = ST_ERR;
            end else begin
               // stopped tick clears duty and history
               running_in   = 1'b0;
               last_duty_in = '0;
               err_prev_in  = '0;
               err_prev2_in = '0;
               done_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ERR: begin
            err_in   = espid_pkg::sat32(64'(speed_target_ff) - 64'(speed_ff));
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            prod_in  = mul_p[63:0];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in   = prod_ff;
            prod_in  = mul_p[63:0];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            acc_in   = espid_pkg::sat_add64(acc_ff, prod_ff);
            prod_in  = mul_p[63:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = espid_pkg::sat_add64(acc_ff, prod_ff);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // clamp duty and shift history unless the step was small
            if (next_duty < 0) begin
               last_duty_in = '0;
            end else if (next_duty > signed'((INCW+2)'(duty_max_ff))) begin
               last_duty_in = duty_max_ff;
            end else begin
               last_duty_in = next_duty[15:0];
            end
            if (inc_mag >= (INCW+2)'(small_step_ff)) begin
               err_prev2_in = err_prev_ff;
               err_prev_in  = err_ff;
            end
            running_in = 1'b1;
            done_in    = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         done_ff       <= 1'b0;
         prev_count_ff <= '0;
         running_ff    <= 1'b0;
         last_duty_ff  <= '0;
         err_prev_ff   <= '0;
         err_prev2_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         done_ff       <= done_in;
         prev_count_ff <= prev_count_in;
         running_ff    <= running_in;
         last_duty_ff  <= last_duty_in;
         err_prev_ff   <= err_prev_in;
         err_prev2_ff  <= err_prev2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      run_ff      <= run_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      speed_ff    <= speed_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_target_ff <= '0;
         speed_scale_ff  <= espid_pkg::SPEED_SCALE_RESET;
         gain_now_ff     <= '0;
         gain_prev_ff    <= '0;
         gain_prev2_ff   <= '0;
         duty_max_ff     <= espid_pkg::DUTY_MAX_RESET;
         small_step_ff   <= espid_pkg::SMALL_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (espid_pkg::csr_index_type'(csr_index))
            espid_pkg::REG_SPEED_TARGET: speed_target_ff <= csr_data;
            espid_pkg::REG_SPEED_SCALE:  speed_scale_ff  <= csr_data[15:0];
            espid_pkg::REG_GAIN_NOW:     gain_now_ff     <= csr_data;
            espid_pkg::REG_GAIN_PREV:    gain_prev_ff    <= csr_data;
            espid_pkg::REG_GAIN_PREV2:   gain_prev2_ff   <= csr_data;
            espid_pkg::REG_DUTY_MAX:     duty_max_ff     <= csr_data[15:0];
            espid_pkg::REG_SMALL_STEP:   small_step_ff   <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

endmodule
